[rtl/qmse_pkg.sv]
// ----------------------------------------------------------------------------
// qmse_pkg
// Shared codes and default sizes for the quad midpoint subdivision engine.
// ----------------------------------------------------------------------------
package qmse_pkg;

	// default sizes
	localparam int VERTEX_DEPTH_DEF = 4096;
	localparam int EDGE_DEPTH_DEF   = 1024;
	localparam int COORD_WIDTH_DEF  = 32;

	// index and coordinate widths seen on the ports
	localparam int IDX_W = 12;
	localparam int IO_W  = 32;

	// input word kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SPLIT = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// result word kinds
	localparam logic [1:0] RES_VERTEX = 2'd0;
	localparam logic [1:0] RES_FACE   = 2'd1;
	localparam logic [1:0] RES_STATUS = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_VFULL = 2'd1;
	localparam logic [1:0] ST_EFULL = 2'd2;

	// edge table entry: two corners and the midpoint index
	typedef struct packed {
		logic [IDX_W-1:0] v1;
		logic [IDX_W-1:0] v2;
		logic [IDX_W-1:0] mid;
	} edge_t;

	// an entry holds an edge when both corners appear, in either order
	function automatic logic edge_hit(
		input logic [IDX_W-1:0] e1,
		input logic [IDX_W-1:0] e2,
		input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b
	);
		edge_hit = ((e1 == a) || (e2 == a)) && ((e1 == b) || (e2 == b));
	endfunction

endpackage

[rtl/quad_midpoint_subdivision_engine.sv]
// A load or end-of-pass word loads its result into the output register once that register
// is free, and the input is ready again with it, so such words are taken one at a time.
// A split word reads its corners, scans the edge table, resolves each of its edges and checks
// for room; short of room it gives only a status word, else its first result and then up to eight more,
// one a cycle while the output side takes them; a reused midpoint takes an emit step with no result.
// The table scan, one entry a cycle through the table RAM read port, sets the split rate.
// Reset clears the counters and control only; both RAMs keep no reset and need no clearing.
// ----------------------------------------------------------------------------
// quad_midpoint_subdivision_engine
// Vertex store and edge table in RAM; splits quads into four sub-faces,
// reusing midpoints already recorded for shared edges.
// ----------------------------------------------------------------------------
module quad_midpoint_subdivision_engine #(
	parameter int VERTEX_DEPTH = qmse_pkg::VERTEX_DEPTH_DEF,
	parameter int EDGE_DEPTH   = qmse_pkg::EDGE_DEPTH_DEF,
	parameter int COORD_WIDTH  = qmse_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       kind,
	input  logic [qmse_pkg::IDX_W-1:0]       corner_a,
	input  logic [qmse_pkg::IDX_W-1:0]       corner_b,
	input  logic [qmse_pkg::IDX_W-1:0]       corner_c,
	input  logic [qmse_pkg::IDX_W-1:0]       corner_d,
	input  logic signed [qmse_pkg::IO_W-1:0] coord_x,
	input  logic signed [qmse_pkg::IO_W-1:0] coord_y,
	input  logic signed [qmse_pkg::IO_W-1:0] coord_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       result_kind,
	output logic [qmse_pkg::IDX_W-1:0]       vertex_index,
	output logic signed [qmse_pkg::IO_W-1:0] out_x,
	output logic signed [qmse_pkg::IO_W-1:0] out_y,
	output logic signed [qmse_pkg::IO_W-1:0] out_z,
	output logic [qmse_pkg::IDX_W-1:0]       face_first,
	output logic [qmse_pkg::IDX_W-1:0]       face_second,
	output logic [qmse_pkg::IDX_W-1:0]       face_third,
	output logic [qmse_pkg::IDX_W-1:0]       face_fourth,
	output logic [1:0]                       status,
	output logic                             last
);

	import qmse_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int MW  = CW + 1;
	localparam int SW  = CW + 2;
	localparam int VIW = $clog2(VERTEX_DEPTH);
	localparam int VCW = $clog2(VERTEX_DEPTH + 1);
	localparam int EIW = $clog2(EDGE_DEPTH);
	localparam int ECW = $clog2(EDGE_DEPTH + 1);
	localparam int EW  = $bits(edge_t);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_END   = 3'd2;
	localparam logic [2:0] S_RDV   = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_RES   = 3'd5;
	localparam logic [2:0] S_CHK   = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	localparam logic [3:0] STEP_LAST = 4'd8;

	logic [2:0]             state_q;
	logic [VCW-1:0]         vcount_q;
	logic [ECW-1:0]         ecount_q;

	// captured input word
	logic [IDX_W-1:0]       cr_q [4];
	logic signed [CW-1:0]   ld_q [3];
	logic [VIW-1:0]         cent_q;

	// corner read sequencing
	logic [2:0]             rd_cnt_q;
	logic                   rd_pend_q;
	logic                   rd_ok_q;
	logic [1:0]             rd_sel_q;
	logic signed [CW-1:0]   pos_q [4][3];
	logic signed [SW-1:0]   sum_q [3];

	// edge scan and resolve
	logic [ECW-1:0]         scan_addr_q;
	logic                   scan_pend_q;
	logic [3:0]             thit_q;
	logic [IDX_W-1:0]       tmid_q [4];
	logic [1:0]             res_c_q;
	logic [2:0]             nfresh_q;
	logic [3:0]             fresh_q;
	logic [VIW-1:0]         mid_q [4];
	logic [3:0]             step_q;

	// output register
	logic                   out_valid_q;
	logic [1:0]             res_kind_q;
	logic [IDX_W-1:0]       vidx_q;
	logic signed [IO_W-1:0] ox_q, oy_q, oz_q;
	logic [IDX_W-1:0]       f1_q, f2_q, f3_q, f4_q;
	logic [1:0]             status_q;
	logic                   last_q;

	// memory ports
	logic                   v_we;
	logic [VIW-1:0]         v_waddr, v_raddr;
	logic [3*CW-1:0]        v_wdata, v_rdata;
	logic                   e_we;
	logic [EIW-1:0]         e_waddr, e_raddr;
	edge_t                  e_wdata, e_rdata;
	logic [EW-1:0]          e_rdata_raw;

	// next output word
	logic                   out_free, out_load, adv;
	logic [1:0]             n_kind, n_status;
	logic [IDX_W-1:0]       n_vidx, n_f1, n_f2, n_f3, n_f4;
	logic signed [IO_W-1:0] n_x, n_y, n_z;
	logic                   n_last;

	logic                   in_acc, rd_issue, scan_issue;
	logic signed [CW-1:0]   rv [3];
	logic signed [CW-1:0]   cent_c [3];
	logic signed [CW-1:0]   mid_c [3];
	logic signed [MW-1:0]   msum [3];
	logic [1:0]             cm, cm1, cf;
	logic [2:0]             npend;
	logic                   vfull, efull;
	logic                   r_found;
	logic [VIW-1:0]         r_mid;

	qmse_ram #(.WIDTH(3 * CW), .DEPTH(VERTEX_DEPTH)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	qmse_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH)) u_eram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata_raw)
	);

	assign e_rdata  = edge_t'(e_rdata_raw);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// read addresses for corner fetch and table scan
	assign rd_issue   = (state_q == S_RDV) && (rd_cnt_q < 3'd4);
	assign scan_issue = (state_q == S_SCAN) && (scan_addr_q < ecount_q);
	assign v_raddr    = VIW'(cr_q[rd_cnt_q[1:0]]);
	assign e_raddr    = EIW'(scan_addr_q);

	// corner data, zero for indices not yet stored
	assign rv[0] = rd_ok_q ? v_rdata[3*CW-1:2*CW] : '0;
	assign rv[1] = rd_ok_q ? v_rdata[2*CW-1:CW]   : '0;
	assign rv[2] = rd_ok_q ? v_rdata[CW-1:0]      : '0;

	// centroid and midpoint arithmetic, floor by arithmetic shift
	assign cm  = 2'(step_q - 4'd1);
	assign cm1 = cm + 2'd1;
	assign cf  = 2'(step_q - 4'd5);
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cent_c[i] = CW'(sum_q[i] >>> 2);
			msum[i]   = MW'(pos_q[cm][i]) + MW'(pos_q[cm1][i]);
			mid_c[i]  = CW'(msum[i] >>> 1);
		end
	end

	// room checks for the pending split
	assign npend = 3'(fresh_q[0]) + 3'(fresh_q[1]) + 3'(fresh_q[2]) + 3'(fresh_q[3]);
	assign vfull = (32'(vcount_q) + 32'd1 + 32'(npend)) > 32'(VERTEX_DEPTH);
	assign efull = (32'(ecount_q) + 32'(npend)) > 32'(EDGE_DEPTH);

	// resolve one edge: table hit, then earlier new edges of this face
	always_comb begin
		r_found = thit_q[res_c_q];
		r_mid   = VIW'(tmid_q[res_c_q]);
		for (int j = 0; j < 3; j++) begin
			if ((2'(j) < res_c_q) && fresh_q[j] &&
			    edge_hit(cr_q[j], cr_q[(j + 1) % 4], cr_q[res_c_q], cr_q[res_c_q + 2'd1])) begin
				r_found = 1'b1;
				r_mid   = mid_q[j];
			end
		end
		if (!r_found) begin
			r_mid = VIW'(32'(vcount_q) + 32'd1 + 32'(nfresh_q));
		end
	end

	// result word and memory writes
	always_comb begin
		out_load = 1'b0;
		adv      = 1'b0;
		n_kind   = RES_STATUS;
		n_status = ST_OK;
		n_vidx   = '0;
		n_x      = '0;
		n_y      = '0;
		n_z      = '0;
		n_f1     = '0;
		n_f2     = '0;
		n_f3     = '0;
		n_f4     = '0;
		n_last   = 1'b1;
		v_we     = 1'b0;
		v_waddr  = VIW'(vcount_q);
		v_wdata  = {ld_q[0], ld_q[1], ld_q[2]};
		e_we     = 1'b0;
		e_waddr  = EIW'(ecount_q);
		e_wdata  = '{v1: cr_q[cm], v2: cr_q[cm1], mid: IDX_W'(mid_q[cm])};
		unique case (state_q)
			S_LOAD: begin
				out_load = out_free;
				if (32'(vcount_q) >= 32'(VERTEX_DEPTH)) begin
					n_status = ST_VFULL;
				end else begin
					v_we   = out_free;
					n_kind = RES_VERTEX;
					n_vidx = IDX_W'(vcount_q);
					n_x    = IO_W'(ld_q[0]);
					n_y    = IO_W'(ld_q[1]);
					n_z    = IO_W'(ld_q[2]);
				end
			end
			S_END: begin
				out_load = out_free;
			end
			S_CHK: begin
				out_load = out_free && (vfull || efull);
				n_status = vfull ? ST_VFULL : ST_EFULL;
			end
			S_EMIT: begin
				n_last = (step_q == STEP_LAST);
				if (step_q == 4'd0) begin
					out_load = out_free;
					adv      = out_free;
					v_we     = out_free;
					v_waddr  = cent_q;
					v_wdata  = {cent_c[0], cent_c[1], cent_c[2]};
					n_kind   = RES_VERTEX;
					n_vidx   = IDX_W'(cent_q);
					n_x      = IO_W'(cent_c[0]);
					n_y      = IO_W'(cent_c[1]);
					n_z      = IO_W'(cent_c[2]);
				end else if (step_q < 4'd5) begin
					if (!fresh_q[cm]) begin
						adv = 1'b1;
					end else begin
						out_load = out_free;
						adv      = out_free;
						v_we     = out_free;
						e_we     = out_free;
						v_waddr  = mid_q[cm];
						v_wdata  = {mid_c[0], mid_c[1], mid_c[2]};
						n_kind   = RES_VERTEX;
						n_vidx   = IDX_W'(mid_q[cm]);
						n_x      = IO_W'(mid_c[0]);
						n_y      = IO_W'(mid_c[1]);
						n_z      = IO_W'(mid_c[2]);
					end
				end else begin
					out_load = out_free;
					adv      = out_free;
					n_kind   = RES_FACE;
					n_f1     = cr_q[cf];
					n_f2     = IDX_W'(mid_q[cf]);
					n_f3     = IDX_W'(cent_q);
					n_f4     = IDX_W'(mid_q[cf - 2'd1]);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= '0;
			ecount_q    <= '0;
			rd_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			scan_addr_q <= '0;
			scan_pend_q <= 1'b0;
			res_c_q     <= '0;
			nfresh_q    <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rd_cnt_q  <= '0;
						rd_pend_q <= 1'b0;
						unique case (kind)
							KIND_LOAD:  state_q <= S_LOAD;
							KIND_SPLIT: state_q <= S_RDV;
							KIND_END:   state_q <= S_END;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (v_we) begin
							vcount_q <= vcount_q + VCW'(1);
						end
					end
				end
				S_END: begin
					if (out_free) begin
						ecount_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_RDV: begin
					rd_pend_q <= rd_issue;
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end else if (!rd_pend_q) begin
						scan_addr_q <= '0;
						scan_pend_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_pend_q <= scan_issue;
					if (scan_issue) begin
						scan_addr_q <= scan_addr_q + ECW'(1);
					end else if (!scan_pend_q) begin
						res_c_q  <= '0;
						nfresh_q <= '0;
						state_q  <= S_RES;
					end
				end
				S_RES: begin
					if (!r_found) begin
						nfresh_q <= nfresh_q + 3'd1;
					end
					res_c_q <= res_c_q + 2'd1;
					if (res_c_q == 2'd3) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (vfull || efull) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						step_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (v_we) begin
						vcount_q <= vcount_q + VCW'(1);
					end
					if (e_we) begin
						ecount_q <= ecount_q + ECW'(1);
					end
					if (adv) begin
						step_q <= step_q + 4'd1;
						if (step_q == STEP_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// captured payload, corner positions, table hits
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cr_q[0] <= corner_a;
			cr_q[1] <= corner_b;
			cr_q[2] <= corner_c;
			cr_q[3] <= corner_d;
			ld_q[0] <= CW'(coord_x);
			ld_q[1] <= CW'(coord_y);
			ld_q[2] <= CW'(coord_z);
			cent_q  <= VIW'(vcount_q);
			thit_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end
		if (rd_issue) begin
			rd_sel_q <= rd_cnt_q[1:0];
			rd_ok_q  <= 32'(cr_q[rd_cnt_q[1:0]]) < 32'(vcount_q);
		end
		if ((state_q == S_RDV) && rd_pend_q) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[rd_sel_q][i] <= rv[i];
				sum_q[i]           <= sum_q[i] + SW'(rv[i]);
			end
		end
		if ((state_q == S_SCAN) && scan_pend_q) begin
			for (int c = 0; c < 4; c++) begin
				if (edge_hit(e_rdata.v1, e_rdata.v2, cr_q[c], cr_q[(c + 1) % 4])) begin
					thit_q[c] <= 1'b1;
					tmid_q[c] <= e_rdata.mid;
				end
			end
		end
		if (state_q == S_RES) begin
			fresh_q[res_c_q] <= !r_found;
			mid_q[res_c_q]   <= r_mid;
		end
		if (out_load) begin
			res_kind_q <= n_kind;
			vidx_q     <= n_vidx;
			ox_q       <= n_x;
			oy_q       <= n_y;
			oz_q       <= n_z;
			f1_q       <= n_f1;
			f2_q       <= n_f2;
			f3_q       <= n_f3;
			f4_q       <= n_f4;
			status_q   <= n_status;
			last_q     <= n_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = res_kind_q;
	assign vertex_index = vidx_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign out_z        = oz_q;
	assign face_first   = f1_q;
	assign face_second  = f2_q;
	assign face_third   = f3_q;
	assign face_fourth  = f4_q;
	assign status       = status_q;
	assign last         = last_q;

	// vertex count never passes the store depth
	a_vcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(vcount_q) <= 32'(VERTEX_DEPTH))
		else $error("vertex count beyond store depth");

	// edge count never passes the table depth
	a_ecount_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ecount_q) <= 32'(EDGE_DEPTH))
		else $error("edge count beyond table depth");

	// memories are written only while a word goes to the output register
	a_write_with_word: assert property (@(posedge clk) disable iff (!arst_n)
		(v_we || e_we) |-> out_load)
		else $error("memory write without result word");

	// a vertex result always carries status ok
	a_vertex_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (n_kind == RES_VERTEX)) |-> (n_status == ST_OK))
		else $error("vertex word with error status");

	// the step counter stays within the nine emit slots
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (step_q <= STEP_LAST))
		else $error("emit step out of range");

endmodule

[rtl/qmse_ram.sv]
// ----------------------------------------------------------------------------
// qmse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module qmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/quad_midpoint_subdivision_engine_tb.sv]
// ----------------------------------------------------------------------------
// quad_midpoint_subdivision_engine_tb
// Self-checking bench for the quad subdivision engine. Words are driven on
// the falling edge, and results are sampled on the rising edge. A mesh model
// in the bench predicts the results from its own copy of the vertex store
// and the edge table; typed rows read their result off the word. Directed rows cover coordinate extremes, edge reuse in
// both orders and degenerate faces; a random mix of words follows.
// ----------------------------------------------------------------------------
module quad_midpoint_subdivision_engine_tb;
	import qmse_pkg::*;

	localparam int VDEPTH = 4096;
	localparam int EDEPTH = 1024;

	typedef struct {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  a, b, c, d;
		logic [IO_W-1:0]   x, y, z;
		bit                typed;
	} word_t;

	typedef struct {
		logic [1:0]        rk;
		logic [IDX_W-1:0]  vi;
		logic [IO_W-1:0]   x, y, z;
		logic [IDX_W-1:0]  f1, f2, f3, f4;
		logic [1:0]        st;
		logic              lst;
	} res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] kind;
	logic [IDX_W-1:0] corner_a, corner_b, corner_c, corner_d;
	logic signed [IO_W-1:0] coord_x, coord_y, coord_z;
	logic [1:0] result_kind, status;
	logic [IDX_W-1:0] vertex_index, face_first, face_second, face_third, face_fourth;
	logic signed [IO_W-1:0] out_x, out_y, out_z;
	logic last;

	quad_midpoint_subdivision_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c), .corner_d(corner_d),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .vertex_index(vertex_index),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.face_first(face_first), .face_second(face_second),
		.face_third(face_third), .face_fourth(face_fourth),
		.status(status), .last(last)
	);

	// mesh model state
	logic [IO_W-1:0]  mesh_x [VDEPTH];
	logic [IO_W-1:0]  mesh_y [VDEPTH];
	logic [IO_W-1:0]  mesh_z [VDEPTH];
	int unsigned      mesh_vcount, mesh_ecount;
	logic [IDX_W-1:0] split_v1 [EDEPTH];
	logic [IDX_W-1:0] split_v2 [EDEPTH];
	logic [IDX_W-1:0] split_mid [EDEPTH];

	res_t pending_results[$];
	int   err_count, words_sent, results_seen, splits_done, vfull_seen, efull_seen;
	bit   quiet_tx;
	int   rx_cycle;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#60000000;
		$display("[quad_midpoint_subdivision_engine] ERROR");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// append one expected result
	task automatic expect_res(input res_t r);
		pending_results = {pending_results, r};
	endtask

	function automatic res_t blank_res(input logic [1:0] rk, input logic [1:0] st);
		res_t r;
		r = '{rk: rk, vi: '0, x: '0, y: '0, z: '0, f1: '0, f2: '0, f3: '0, f4: '0,
			st: st, lst: 1'b0};
		return r;
	endfunction

	function automatic logic shares_edge(input logic [IDX_W-1:0] e1, e2, p, q);
		return ((e1 == p) || (e2 == p)) && ((e1 == q) || (e2 == q));
	endfunction

	// mesh model: works out the results of one accepted word
	task automatic mesh_step(input word_t w);
		res_t r;
		logic [IDX_W-1:0] cr [4];
		longint px [4], py [4], pz [4];
		int mid [4];
		bit fresh [4];
		logic [IDX_W-1:0] pv1 [4], pv2 [4];
		int pm [4];
		int npend, nxt, m, cent;
		bit found;
		longint sx, sy, sz;
		case (w.kind)
			KIND_LOAD: begin
				if (mesh_vcount >= VDEPTH) begin
					r = blank_res(RES_STATUS, ST_VFULL);
					vfull_seen++;
				end else begin
					r = blank_res(RES_VERTEX, ST_OK);
					r.vi = mesh_vcount[IDX_W-1:0];
					r.x = w.x; r.y = w.y; r.z = w.z;
					mesh_x[mesh_vcount] = w.x;
					mesh_y[mesh_vcount] = w.y;
					mesh_z[mesh_vcount] = w.z;
					mesh_vcount++;
				end
				r.lst = 1'b1;
				expect_res(r);
			end
			KIND_END: begin
				mesh_ecount = 0;
				r = blank_res(RES_STATUS, ST_OK);
				r.lst = 1'b1;
				expect_res(r);
			end
			KIND_SPLIT: begin
				cr[0] = w.a; cr[1] = w.b; cr[2] = w.c; cr[3] = w.d;
				for (int i = 0; i < 4; i++) begin
					if (cr[i] < mesh_vcount) begin
						px[i] = longint'(signed'(mesh_x[cr[i]]));
						py[i] = longint'(signed'(mesh_y[cr[i]]));
						pz[i] = longint'(signed'(mesh_z[cr[i]]));
					end else begin
						px[i] = 0; py[i] = 0; pz[i] = 0;
					end
				end
				cent = mesh_vcount;
				nxt = mesh_vcount + 1;
				npend = 0;
				// look up each edge; the latest matching entry wins
				for (int i = 0; i < 4; i++) begin
					found = 1'b0;
					m = 0;
					for (int e = 0; e < mesh_ecount; e++)
						if (shares_edge(split_v1[e], split_v2[e], cr[i], cr[(i+1)%4])) begin
							m = split_mid[e]; found = 1'b1;
						end
					for (int e = 0; e < npend; e++)
						if (shares_edge(pv1[e], pv2[e], cr[i], cr[(i+1)%4])) begin
							m = pm[e]; found = 1'b1;
						end
					if (!found) begin
						m = nxt++;
						pv1[npend] = cr[i]; pv2[npend] = cr[(i+1)%4]; pm[npend] = m;
						npend++;
					end
					mid[i] = m;
					fresh[i] = !found;
				end
				if (mesh_vcount + 1 + npend > VDEPTH) begin
					r = blank_res(RES_STATUS, ST_VFULL);
					r.lst = 1'b1;
					expect_res(r);
					vfull_seen++;
				end else if (mesh_ecount + npend > EDEPTH) begin
					r = blank_res(RES_STATUS, ST_EFULL);
					r.lst = 1'b1;
					expect_res(r);
					efull_seen++;
				end else begin
					// centroid, floor of the sum over four
					sx = (px[0] + px[1] + px[2] + px[3]) >>> 2;
					sy = (py[0] + py[1] + py[2] + py[3]) >>> 2;
					sz = (pz[0] + pz[1] + pz[2] + pz[3]) >>> 2;
					r = blank_res(RES_VERTEX, ST_OK);
					r.vi = cent[IDX_W-1:0];
					r.x = sx[IO_W-1:0]; r.y = sy[IO_W-1:0]; r.z = sz[IO_W-1:0];
					mesh_x[cent] = r.x; mesh_y[cent] = r.y; mesh_z[cent] = r.z;
					expect_res(r);
					// fresh midpoints, floor of the sum over two
					for (int i = 0; i < 4; i++) begin
						if (fresh[i]) begin
							sx = (px[i] + px[(i+1)%4]) >>> 1;
							sy = (py[i] + py[(i+1)%4]) >>> 1;
							sz = (pz[i] + pz[(i+1)%4]) >>> 1;
							r = blank_res(RES_VERTEX, ST_OK);
							r.vi = mid[i][IDX_W-1:0];
							r.x = sx[IO_W-1:0]; r.y = sy[IO_W-1:0]; r.z = sz[IO_W-1:0];
							mesh_x[mid[i]] = r.x; mesh_y[mid[i]] = r.y; mesh_z[mid[i]] = r.z;
							expect_res(r);
						end
					end
					mesh_vcount = nxt;
					for (int e = 0; e < npend; e++) begin
						split_v1[mesh_ecount] = pv1[e];
						split_v2[mesh_ecount] = pv2[e];
						split_mid[mesh_ecount] = pm[e][IDX_W-1:0];
						mesh_ecount++;
					end
					// four sub-faces
					for (int i = 0; i < 4; i++) begin
						r = blank_res(RES_FACE, ST_OK);
						r.f1 = cr[i];
						r.f2 = mid[i][IDX_W-1:0];
						r.f3 = cent[IDX_W-1:0];
						r.f4 = mid[(i+3)%4][IDX_W-1:0];
						r.lst = (i == 3);
						expect_res(r);
					end
					splits_done++;
				end
			end
			default: ;
		endcase
	endtask

	// drive one word and run the model at its acceptance
	task automatic send_word(input word_t w);
		int n_prior;
		res_t r;
		while (!quiet_tx && $urandom_range(0, 99) < 26) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = w.kind;
		corner_a = w.a; corner_b = w.b; corner_c = w.c; corner_d = w.d;
		coord_x = w.x; coord_y = w.y; coord_z = w.z;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		n_prior = pending_results.size();
		mesh_step(w);
		// typed rows: the load echo and end-of-pass status are read off directly
		if (w.typed && pending_results.size() == n_prior + 1) begin
			r = blank_res(w.kind == KIND_END ? RES_STATUS : RES_VERTEX, ST_OK);
			if (w.kind == KIND_LOAD) begin
				r.vi = pending_results[n_prior].vi;
				r.x = w.x; r.y = w.y; r.z = w.z;
			end
			r.lst = 1'b1;
			pending_results[n_prior] = r;
		end
		words_sent++;
		@(negedge clk);
	endtask

	function automatic word_t load_word(input logic [IO_W-1:0] x, y, z);
		word_t w;
		w = '{kind: KIND_LOAD, a: '0, b: '0, c: '0, d: '0, x: x, y: y, z: z, typed: 1'b0};
		return w;
	endfunction

	function automatic word_t split_word(input int a, b, c, d);
		word_t w;
		w = '{kind: KIND_SPLIT, a: a[IDX_W-1:0], b: b[IDX_W-1:0], c: c[IDX_W-1:0],
			d: d[IDX_W-1:0], x: '0, y: '0, z: '0, typed: 1'b0};
		return w;
	endfunction

	function automatic word_t plain_word(input logic [1:0] k);
		word_t w;
		w = '{kind: k, a: $urandom, b: $urandom, c: $urandom, d: $urandom,
			x: $urandom, y: $urandom, z: $urandom, typed: 1'b0};
		return w;
	endfunction

	// random coordinate, sometimes an extreme
	function automatic logic [IO_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 7)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_corner(input int span);
		int lo;
		lo = (int'(mesh_vcount) > span) ? int'(mesh_vcount) - span : 0;
		return $urandom_range(lo, mesh_vcount - 1);
	endfunction

	// output side: random stalls, a stall-free stretch, a long hold-off, then random stalls again
	initial begin
		out_ready = 1'b0;
		rx_cycle = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle >= 600 && rx_cycle < 1000)
				out_ready = 1'b1;
			else if (rx_cycle >= 1000 && rx_cycle < 1300)
				out_ready = 1'b0;
			else
				out_ready = ($urandom_range(0, 99) >= 26);
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing expected, kind %0d", result_kind));
			end else begin
				e = pending_results.pop_front();
				if (result_kind !== e.rk)   report($sformatf("result_kind %0d exp %0d", result_kind, e.rk));
				if (vertex_index !== e.vi)  report($sformatf("vertex_index %0d exp %0d", vertex_index, e.vi));
				if (out_x !== e.x)          report($sformatf("out_x %h exp %h", out_x, e.x));
				if (out_y !== e.y)          report($sformatf("out_y %h exp %h", out_y, e.y));
				if (out_z !== e.z)          report($sformatf("out_z %h exp %h", out_z, e.z));
				if (face_first !== e.f1)    report($sformatf("face_first %0d exp %0d", face_first, e.f1));
				if (face_second !== e.f2)   report($sformatf("face_second %0d exp %0d", face_second, e.f2));
				if (face_third !== e.f3)    report($sformatf("face_third %0d exp %0d", face_third, e.f3));
				if (face_fourth !== e.f4)   report($sformatf("face_fourth %0d exp %0d", face_fourth, e.f4));
				if (status !== e.st)        report($sformatf("status %0d exp %0d", status, e.st));
				if (last !== e.lst)         report($sformatf("last %0d exp %0d", last, e.lst));
			end
		end
	end

	// stimulus
	initial begin
		word_t directed [$];
		word_t w;
		int wait_cycles;
		err_count = 0; words_sent = 0; results_seen = 0;
		splits_done = 0; vfull_seen = 0; efull_seen = 0;
		mesh_vcount = 0; mesh_ecount = 0;
		quiet_tx = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		corner_a = '0; corner_b = '0; corner_c = '0; corner_d = '0;
		coord_x = '0; coord_y = '0; coord_z = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: coordinate extremes, reuse in both orders, degenerate face
		w = load_word(32'h7fff_ffff, 32'h8000_0000, 32'h0);          w.typed = 1; directed = {directed, w};
		w = load_word(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);  w.typed = 1; directed = {directed, w};
		w = load_word(32'h0001_0000, 32'hffff_0000, 32'h1234_5678);  w.typed = 1; directed = {directed, w};
		w = load_word(32'hffff_fffd, 32'h5, 32'hffff_fff9);          w.typed = 1; directed = {directed, w};
		directed = {directed, split_word(0, 1, 2, 3)};
		directed = {directed, split_word(3, 2, 1, 0)};
		directed = {directed, split_word(0, 1, 4, 5)};
		directed = {directed, split_word(2, 2, 2, 2)};
		directed = {directed, split_word(1, 3, 1, 3)};
		directed = {directed, plain_word(2'd3)};
		w = plain_word(KIND_END);                                    w.typed = 1; directed = {directed, w};
		directed = {directed, split_word(0, 1, 2, 3)};
		directed = {directed, split_word(1, 0, 3, 2)};
		w = load_word(32'hffff_ffff, 32'h0, 32'h8000_0000);          w.typed = 1; directed = {directed, w};
		directed = {directed, split_word(0, 0, 1, 1)};
		w = plain_word(KIND_END);                                    w.typed = 1; directed = {directed, w};
		foreach (directed[i])
			send_word(directed[i]);

		// random part: mostly faces, nearly all over nearby vertices so edges get shared
		for (int n = 0; n < 184; n++) begin
			quiet_tx = (n >= 60 && n < 110);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: w = load_word(rand_coord(), rand_coord(), rand_coord());
				7: w = plain_word(KIND_END);
				8: w = plain_word(2'd3);
				9: w = split_word(rand_corner(10000), rand_corner(10000),
					rand_corner(10000), rand_corner(10000));
				default: w = split_word(rand_corner(10), rand_corner(10),
					rand_corner(10), rand_corner(10));
			endcase
			send_word(w);
		end
		quiet_tx = 1'b0;
		in_valid = 1'b0;

		// drain
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_results.size() != 0)
			report($sformatf("%0d results never arrived", pending_results.size()));
		repeat (100) @(posedge clk);

		$display("run: %0d words sent, %0d results checked, %0d faces split",
			words_sent, results_seen, splits_done);
		$display("run: store-full statuses %0d, table-full statuses %0d, mismatches %0d",
			vfull_seen, efull_seen, err_count);
		if (err_count == 0)
			$display("[quad_midpoint_subdivision_engine] OK");
		else
			$display("[quad_midpoint_subdivision_engine] ERROR");
		$finish;
	end

endmodule
